/* design/binary_to_decimal_ascii_defines.svh */
// assertion macros for the top-level design file
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// property checked on every rising clk edge, off while arst_n is low
`define B2DA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define B2DA_ASSERT_NEVER(label, cond, msg) \
	`B2DA_ASSERT(label, !(cond), msg)

`endif

/* design/b2da_pkg.sv */
`timescale 1ns / 1ps

package b2da_pkg;

	localparam int VALUE_W    = 31;
	localparam int MIN_W      = 5;
	localparam int CHAR_W     = 8;
	localparam int CNT_W      = 5;
	localparam int IDX_W      = 5;
	localparam int MAX_DIGITS = 16;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int STEP_W     = $clog2(VALUE_W);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NUL  = 8'h00;

	typedef struct packed {
		logic             load;
		logic [BCD_W-1:0] bcd;
		logic [MIN_W-1:0] pad;
	} emit_req_t;

endpackage

/* design/b2da_if.sv */
`timescale 1ns / 1ps

interface b2da_in_if;
	import b2da_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic [MIN_W-1:0]   min_digits;

	modport source (output valid, output value, output min_digits, input ready);
	modport sink (input valid, input value, input min_digits, output ready);
endinterface

interface b2da_out_if;
	import b2da_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              last;
	logic [CNT_W-1:0]  digit_count;

	modport source (output valid, output char_out, output last, output digit_count,
		input ready);
	modport sink (input valid, input char_out, input last, input digit_count,
		output ready);
endinterface

/* design/b2da_dabble.sv */
`timescale 1ns / 1ps

module b2da_dabble (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [b2da_pkg::VALUE_W-1:0] value,
	output logic [b2da_pkg::BCD_W-1:0]   bcd,
	output logic                         done
);
	import b2da_pkg::*;

	logic [VALUE_W-1:0] val_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   adj;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               done_q;

	// add-3 correction on every bcd digit before the shift
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], val_q[VALUE_W-1]};
		end
	end

	assign bcd  = bcd_q;
	assign done = done_q;

endmodule

/* design/b2da_emit.sv */
`timescale 1ns / 1ps

module b2da_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  b2da_pkg::emit_req_t req,
	b2da_out_if.source          dout,
	output logic                done
);
	import b2da_pkg::*;

	logic [BCD_W-1:0]  bcd_q;
	logic [MIN_W-1:0]  pad_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic              started_q;
	logic              scan_q;
	logic              term_q;
	logic              ovalid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              adv;
	logic              in_bcd;
	logic [3:0]        dig;
	logic              emit;

	assign adv    = !ovalid_q || dout.ready;
	assign in_bcd = idx_q < IDX_W'(BCD_DIGITS);
	assign dig    = in_bcd ? bcd_q[BCD_W-1 -: 4] : 4'd0;
	assign emit   = started_q || (idx_q < pad_q) || (dig != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= 1'b0;
			term_q    <= 1'b0;
			ovalid_q  <= 1'b0;
			started_q <= 1'b0;
		end else begin
			if (req.load) begin
				scan_q    <= 1'b1;
				term_q    <= 1'b0;
				started_q <= 1'b0;
			end else if (scan_q && adv) begin
				ovalid_q <= emit;
				if (emit) begin
					started_q <= 1'b1;
				end
				if (idx_q == '0) begin
					scan_q <= 1'b0;
					term_q <= 1'b1;
				end
			end else if (term_q && adv) begin
				ovalid_q <= 1'b1;
				term_q   <= 1'b0;
			end else if (ovalid_q && dout.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			bcd_q   <= req.bcd;
			pad_q   <= req.pad;
			count_q <= '0;
			if (req.pad > IDX_W'(BCD_DIGITS)) begin
				idx_q <= req.pad - 1'b1;
			end else begin
				idx_q <= IDX_W'(BCD_DIGITS - 1);
			end
		end else if (scan_q && adv) begin
			if (emit) begin
				char_q <= ASCII_ZERO + {4'd0, dig};
				last_q <= 1'b0;
				cnt_q  <= '0;
				if (!started_q) begin
					count_q <= idx_q + 1'b1;
				end
			end
			if (in_bcd) begin
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			end
			if (idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
		end else if (term_q && adv) begin
			char_q <= ASCII_NUL;
			last_q <= 1'b1;
			cnt_q  <= count_q;
		end
	end

	assign dout.valid       = ovalid_q;
	assign dout.char_out    = char_q;
	assign dout.last        = last_q;
	assign dout.digit_count = cnt_q;
	assign done             = ovalid_q && dout.ready && last_q;

endmodule

/* design/binary_to_decimal_ascii.sv */
// Converts a 31-bit unsigned value to decimal ASCII text, most significant digit first,
// left-padded with '0' up to min_digits (saturated at MAX_DIGITS), then a NUL beat with
// last set that carries the digit count. One item is in flight at a time: after the
// input beat, a double-dabble shifter converts the value to BCD, then a digit scanner
// walks max(10, padded count) positions and then emits the NUL, holding while the
// output is stalled. The next input beat is taken once the NUL beat has been taken.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii (
	input  logic       clk,
	input  logic       arst_n,
	b2da_in_if.sink    din,
	b2da_out_if.source dout
);
	import b2da_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [MIN_W-1:0] pad_q;
	logic             accept;
	logic [BCD_W-1:0] dab_bcd;
	logic             dab_done;
	logic             emit_done;
	emit_req_t        req;

	assign din.ready = (state_q == ST_IDLE);
	assign accept    = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (dab_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// saturate the minimum digit count
	always_ff @(posedge clk) begin
		if (accept) begin
			if ({1'b0, din.min_digits} > (MIN_W + 1)'(MAX_DIGITS)) begin
				pad_q <= MIN_W'(MAX_DIGITS);
			end else begin
				pad_q <= din.min_digits;
			end
		end
	end

	b2da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (din.value),
		.bcd    (dab_bcd),
		.done   (dab_done)
	);

	assign req.load = dab_done;
	assign req.bcd  = dab_bcd;
	assign req.pad  = pad_q;

	b2da_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.dout   (dout),
		.done   (emit_done)
	);

	`B2DA_ASSERT(a_out_only_emit, dout.valid |-> state_q == ST_EMIT, "output beat outside emit")
	`B2DA_ASSERT_NEVER(a_ready_while_out, din.ready && dout.valid, "input ready with output pending")
	`B2DA_ASSERT(a_accept_conv, accept |=> state_q == ST_CONV, "accepted beat did not start conversion")
	`B2DA_ASSERT(a_term_nul, dout.valid && dout.last |-> dout.char_out == ASCII_NUL, "last beat not NUL")
	`B2DA_ASSERT(a_digit_zero_cnt, dout.valid && !dout.last |-> dout.digit_count == '0, "digit beat with count")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
	import b2da_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
		logic [CNT_W-1:0]  count;
	} char_beat_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [MIN_W-1:0]   min_digits;
		bit                 typed;
		string              text;
	} stim_row_t;

	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM   = 110;

	logic clk;
	logic arst_n;
	int   failures;
	bit   steady_flow;

	char_beat_t pending_chars[$];
	stim_row_t  directed_rows[N_DIRECTED];

	b2da_in_if  din_if ();
	b2da_out_if dout_if ();

	binary_to_decimal_ascii u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if.sink),
		.dout   (dout_if.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic void push_beat(logic [CHAR_W-1:0] code, logic last,
		logic [CNT_W-1:0] count);
		char_beat_t b;
		b.code = code;
		b.last = last;
		b.count = count;
		pending_chars.push_back(b);
	endfunction

	// expected characters of one value, padded and terminated
	function automatic void predict_text(logic [VALUE_W-1:0] value,
		logic [MIN_W-1:0] min_digits);
		logic [3:0] digs[BCD_DIGITS];
		logic [VALUE_W-1:0] v;
		int n;
		int pad;
		int total;
		v = value;
		n = 0;
		while (v != 0 && n < BCD_DIGITS) begin
			digs[n] = 4'(v % 10);
			v = VALUE_W'(v / 10);
			n++;
		end
		pad = (min_digits > MAX_DIGITS) ? MAX_DIGITS : int'(min_digits);
		total = (n > pad) ? n : pad;
		for (int i = n; i < total; i++)
			push_beat(ASCII_ZERO, 1'b0, '0);
		for (int i = n; i > 0; i--)
			push_beat(ASCII_ZERO + CHAR_W'(digs[i-1]), 1'b0, '0);
		push_beat(ASCII_NUL, 1'b1, CNT_W'(total));
	endfunction

	function automatic void push_text(string text);
		for (int i = 0; i < text.len(); i++)
			push_beat(CHAR_W'(text[i]), 1'b0, '0);
		push_beat(ASCII_NUL, 1'b1, CNT_W'(text.len()));
	endfunction

	task automatic send_value(logic [VALUE_W-1:0] value, logic [MIN_W-1:0] min_digits,
		bit typed, string text);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.value <= value;
		din_if.min_digits <= min_digits;
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		if (typed)
			push_text(text);
		else
			predict_text(value, min_digits);
		@(negedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] p;
		int k;
		case ($urandom_range(0, 3))
			0: pick_value = VALUE_W'($urandom_range(0, 999));
			1: begin
				k = $urandom_range(0, 9);
				p = VALUE_W'(1);
				repeat (k) p = VALUE_W'(p * 10);
				pick_value = $urandom_range(0, 1) ? p : p - 1'b1;
			end
			default: pick_value = VALUE_W'($urandom);
		endcase
	endfunction

	function automatic logic [MIN_W-1:0] pick_min();
		if ($urandom_range(0, 3) == 0)
			pick_min = MIN_W'($urandom_range(11, 31));
		else
			pick_min = MIN_W'($urandom_range(0, 12));
	endfunction

	// output side: random stalls (none in steady stretches), every beat checked against the oldest expectation
	initial begin
		char_beat_t want;
		int gap;
		dout_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = steady_flow ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				dout_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			dout_if.ready <= 1'b1;
			@(posedge clk);
			while (!dout_if.valid)
				@(posedge clk);
			if (pending_chars.size() == 0) begin
				$error("unexpected beat: char_out %0h last %0b digit_count %0d",
					dout_if.char_out, dout_if.last, dout_if.digit_count);
				failures++;
			end else begin
				want = pending_chars.pop_front();
				if (dout_if.char_out !== want.code) begin
					$error("char_out: expected %0h, got %0h", want.code, dout_if.char_out);
					failures++;
				end
				if (dout_if.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, dout_if.last);
					failures++;
				end
				if (dout_if.digit_count !== want.count) begin
					$error("digit_count: expected %0d, got %0d", want.count,
						dout_if.digit_count);
					failures++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		failures = 0;
		steady_flow = 1'b0;
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.value = '0;
		din_if.min_digits = '0;
		directed_rows = '{
			'{31'd0, 5'd0, 1'b1, ""},
			'{31'd0, 5'd1, 1'b1, "0"},
			'{31'd0, 5'd16, 1'b1, "0000000000000000"},
			'{31'd0, 5'd31, 1'b1, "0000000000000000"},
			'{31'd0, 5'd17, 1'b1, "0000000000000000"},
			'{31'd2147483647, 5'd0, 1'b1, "2147483647"},
			'{31'd2147483647, 5'd31, 1'b1, "0000002147483647"},
			'{31'd1, 5'd0, 1'b1, "1"},
			'{31'd9, 5'd0, 1'b0, ""},
			'{31'd10, 5'd0, 1'b0, ""},
			'{31'd99, 5'd2, 1'b0, ""},
			'{31'd100, 5'd2, 1'b0, ""},
			'{31'd1000000000, 5'd0, 1'b1, "1000000000"},
			'{31'd999999999, 5'd10, 1'b1, "0999999999"},
			'{31'd12345, 5'd8, 1'b0, ""},
			'{31'd7, 5'd17, 1'b0, ""},
			'{31'd1431655765, 5'd0, 1'b0, ""},
			'{31'd715827882, 5'd21, 1'b0, ""},
			'{31'd1073741824, 5'd15, 1'b0, ""},
			'{31'd42, 5'd10, 1'b0, ""}
		};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_value(directed_rows[i].value, directed_rows[i].min_digits,
				directed_rows[i].typed, directed_rows[i].text);

		for (int i = 0; i < N_RANDOM; i++) begin
			// every third stretch of 25 items runs with no idle cycles
			steady_flow = ((i / 25) % 3) == 2;
			send_value(pick_value(), pick_min(), 1'b0, "");
		end
		din_if.valid <= 1'b0;
		steady_flow = 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (failures == 0 && pending_chars.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
